>>> sv/lscc_pkg.sv
package lscc_pkg;

    localparam int RANGE_W = 16;
    localparam int COORD_W = 18;
    localparam int SUM_W   = 30;
    localparam int TALLY_W = 12;
    localparam int NORM_W  = 34;
    localparam int TRIG_W  = 16;
    localparam int QUO_W   = 30;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 12'd4095;

    localparam logic [1:0] REG_RANGE_LIMIT = 2'd0;
    localparam logic [1:0] REG_GAP_THRESH  = 2'd1;
    localparam logic [1:0] REG_ANGLE_START = 2'd2;
    localparam logic [1:0] REG_ANGLE_STEP  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic sin_mul;    // trig steps
        logic [2:0] trig_step;
        logic trig_sel;   // 0 cos, 1 sin
        logic scale;      // range * trig
        logic gap_calc;
        logic update;     // classify and accumulate
        logic div_start;
        logic div_step;
        logic div_done;   // compare mean against best
        logic emit;
        logic clear;
    } lscc_cmd_t;

    typedef struct packed {
        logic valid_smp;
        logic need_close;  // segment must be closed before accumulation
        logic close_last;  // open segment at scan end
        logic last;
    } lscc_stat_t;

endpackage

>>> sv/lscc_ctrl.sv
module lscc_ctrl
    import lscc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       m_ready,
    output logic       m_valid,
    input  lscc_stat_t stat,
    output lscc_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TRIG  = 4'd1;
    localparam logic [3:0] ST_SCALE = 4'd2;
    localparam logic [3:0] ST_GAP   = 4'd3;
    localparam logic [3:0] ST_DIVA  = 4'd4;
    localparam logic [3:0] ST_DIVB  = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_ENDA  = 4'd7;
    localparam logic [3:0] ST_ENDB  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_GAPB  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_reg, out_next;

    assign s_ready = (state_reg == ST_IDLE) && !out_reg;
    assign m_valid = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            out_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            out_reg   <= out_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_next   = out_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !out_reg) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_TRIG;
                end
            end
            ST_TRIG: begin
                // four multiply steps for cos then four for sin
                cmd.sin_mul   = 1'b1;
                cmd.trig_step = cnt_reg[1:0] == 2'd0 ? 3'd0 : {1'b0, cnt_reg[1:0]};
                cmd.trig_sel  = cnt_reg[2];
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7) begin
                    state_next = ST_SCALE;
                    cnt_next   = '0;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_GAP;
            end
            ST_GAP: begin
                cmd.gap_calc = 1'b1;
                state_next   = ST_GAPB;
            end
            ST_GAPB: begin
                if (stat.need_close) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIVA;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_DIVA: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1)) state_next = ST_DIVB;
            end
            ST_DIVB: begin
                cmd.div_done = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = stat.last ? ST_ENDA : ST_IDLE;
            end
            ST_ENDA: begin
                if (stat.close_last) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_ENDB;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_ENDB: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.close_last) cmd.div_done = 1'b1;
                cmd.emit   = 1'b1;
                cmd.clear  = 1'b1;
                out_next   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

>>> sv/lscc_dp.sv
module lscc_dp
    import lscc_pkg::*;
#(
    parameter int MAX_POINTS = 2048
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lscc_cmd_t                 cmd,
    output lscc_stat_t                stat,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic [RANGE_W-1:0]        s_range_mm,
    input  logic                      s_no_return,
    input  logic                      s_scan_last,
    output logic signed [16:0]        m_cluster_x_mm,
    output logic signed [16:0]        m_cluster_y_mm,
    output logic                      m_cluster_found,
    output logic [TALLY_W-1:0]        m_valid_points,
    output logic [TALLY_W-1:0]        m_segment_total
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [15:0] lim_reg, gap_reg, ast_reg, asp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= 16'd30000;
            gap_reg <= 16'd300;
            ast_reg <= 16'h8000;
            asp_reg <= 16'd32;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RANGE_LIMIT: lim_reg <= cfg_data;
                REG_GAP_THRESH:  gap_reg <= cfg_data;
                REG_ANGLE_START: ast_reg <= cfg_data;
                REG_ANGLE_STEP:  asp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // scan state
    logic [IDX_W-1:0]         idx_reg;
    logic                     inseg_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, best_x_reg, best_y_reg;
    logic signed [SUM_W-1:0]  sx_reg, sy_reg;
    logic [TALLY_W-1:0]       np_reg, vt_reg, st_reg;
    logic [NORM_W-1:0]        best_n_reg;

    // sample registers
    logic [RANGE_W-1:0] rng_reg;
    logic               valid_reg, last_reg;
    logic [15:0]        ang_reg;
    logic [15:0]        a_cur;
    logic [15:0]        t2_reg;
    logic [17:0]        p_reg;
    logic               neg_reg;
    logic [15:0]        cos_reg, sin_reg;
    logic               cneg_reg, sneg_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic               brk_reg;

    assign a_cur = cmd.trig_sel ? ang_reg : ang_reg + 16'd16384;

    logic [1:0]  quad;
    logic [13:0] rr;
    logic [14:0] tt;
    assign quad = a_cur[15:14];
    assign rr   = a_cur[13:0];
    assign tt   = quad[0] ? (15'd16384 - {1'b0, rr}) : {1'b0, rr};

    logic [29:0] m1;
    logic [33:0] m2;
    logic [32:0] m3;
    logic [32:0] sq;
    assign m1 = 30'(tt) * 30'(tt);
    assign m2 = 34'(p_reg) * 34'(t2_reg);
    assign m3 = 33'(p_reg) * 33'(tt);
    assign sq = m3 >> 15;

    // range scale
    logic [31:0] mc, ms;
    logic [17:0] vc, vs;
    assign mc = 32'(rng_reg) * 32'(cos_reg);
    assign ms = 32'(rng_reg) * 32'(sin_reg);
    assign vc = 18'((mc + 32'd16384) >> 15);
    assign vs = 18'((ms + 32'd16384) >> 15);

    // gap
    logic signed [COORD_W:0] dx, dy;
    logic [37:0] d2;
    logic [31:0] g2;
    assign dx = (COORD_W+1)'(x_reg) - (COORD_W+1)'(px_reg);
    assign dy = (COORD_W+1)'(y_reg) - (COORD_W+1)'(py_reg);
    assign d2 = 38'(38'(dx * dx) + 38'(dy * dy));
    assign g2 = 32'(gap_reg) * 32'(gap_reg);

    // serial divider for both means
    logic [SUM_W-1:0] qx_reg, qy_reg, rx_reg, ry_reg;
    logic             nx_reg, ny_reg;
    logic [SUM_W-1:0] rx_sh, ry_sh;
    assign rx_sh = {rx_reg[SUM_W-2:0], qx_reg[SUM_W-1]};
    assign ry_sh = {ry_reg[SUM_W-2:0], qy_reg[SUM_W-1]};

    logic signed [COORD_W-1:0] mx, my;
    logic [NORM_W-1:0] nrm;
    assign mx = nx_reg ? -COORD_W'(qx_reg) : COORD_W'(qx_reg);
    assign my = ny_reg ? -COORD_W'(qy_reg) : COORD_W'(qy_reg);
    assign nrm = NORM_W'(mx * mx) + NORM_W'(my * my);

    assign stat.valid_smp  = valid_reg;
    assign stat.need_close = (!valid_reg && inseg_reg) || (valid_reg && inseg_reg && brk_reg);
    assign stat.close_last = inseg_reg;
    assign stat.last       = last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rng_reg   <= s_range_mm;
            valid_reg <= !s_no_return && (s_range_mm < lim_reg);
            last_reg  <= s_scan_last;
            ang_reg   <= ast_reg + 16'(asp_reg * 16'(idx_reg));
        end
        if (cmd.sin_mul) begin
            unique case (cmd.trig_step[1:0])
                2'd0: begin
                    t2_reg  <= 16'(m1 >> 14);
                    neg_reg <= quad[1];
                end
                2'd1: p_reg <= 18'(42047 - ((32'd4640 * 32'(t2_reg)) >> 14));
                2'd2: p_reg <= 18'(34'd102944 - (m2 >> 14));
                2'd3: begin
                    if (cmd.trig_sel) begin
                        sin_reg  <= sq > 33'd32767 ? 16'd32767 : 16'(sq);
                        sneg_reg <= neg_reg;
                    end else begin
                        cos_reg  <= sq > 33'd32767 ? 16'd32767 : 16'(sq);
                        cneg_reg <= neg_reg;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.scale) begin
            x_reg <= cneg_reg ? -vc : vc;
            y_reg <= sneg_reg ? -vs : vs;
        end
        if (cmd.gap_calc) brk_reg <= d2 >= 38'(g2);
        if (cmd.div_start) begin
            nx_reg   <= sx_reg[SUM_W-1];
            ny_reg   <= sy_reg[SUM_W-1];
            qx_reg   <= sx_reg[SUM_W-1] ? -sx_reg : sx_reg;
            qy_reg   <= sy_reg[SUM_W-1] ? -sy_reg : sy_reg;
            rx_reg   <= '0;
            ry_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (rx_sh >= SUM_W'(np_reg)) begin
                rx_reg <= rx_sh - SUM_W'(np_reg);
                qx_reg <= {qx_reg[SUM_W-2:0], 1'b1};
            end else begin
                rx_reg <= rx_sh;
                qx_reg <= {qx_reg[SUM_W-2:0], 1'b0};
            end
            if (ry_sh >= SUM_W'(np_reg)) begin
                ry_reg <= ry_sh - SUM_W'(np_reg);
                qy_reg <= {qy_reg[SUM_W-2:0], 1'b1};
            end else begin
                ry_reg <= ry_sh;
                qy_reg <= {qy_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.emit) begin
            m_cluster_found <= st_reg != '0;
            m_valid_points  <= vt_reg;
            m_segment_total <= st_reg;
            // a segment still open at scan end may beat the stored best
            if (inseg_reg && np_reg != '0 && nrm < best_n_reg) begin
                m_cluster_x_mm <= 17'(mx);
                m_cluster_y_mm <= 17'(my);
            end else if (st_reg != '0) begin
                m_cluster_x_mm <= 17'(best_x_reg);
                m_cluster_y_mm <= 17'(best_y_reg);
            end else begin
                m_cluster_x_mm <= '0;
                m_cluster_y_mm <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            idx_reg    <= '0;
            inseg_reg  <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            np_reg     <= '0;
            best_n_reg <= '1;
            best_x_reg <= '0;
            best_y_reg <= '0;
            vt_reg     <= '0;
            st_reg     <= '0;
        end else begin
            if (cmd.div_done && np_reg != '0 && nrm < best_n_reg) begin
                best_n_reg <= nrm;
                best_x_reg <= mx;
                best_y_reg <= my;
            end
            if (cmd.update) begin
                idx_reg <= (32'(idx_reg) + 1 >= MAX_POINTS) ? '0 : idx_reg + 1'b1;
                if (!valid_reg) begin
                    inseg_reg <= 1'b0;
                    if (inseg_reg) begin
                        sx_reg <= '0;
                        sy_reg <= '0;
                        np_reg <= '0;
                    end
                end else begin
                    if (vt_reg != TALLY_MAX) vt_reg <= vt_reg + 1'b1;
                    if ((!inseg_reg || brk_reg) && st_reg != TALLY_MAX)
                        st_reg <= st_reg + 1'b1;
                    inseg_reg <= 1'b1;
                    px_reg    <= x_reg;
                    py_reg    <= y_reg;
                    if (inseg_reg && brk_reg) begin
                        sx_reg <= SUM_W'(x_reg);
                        sy_reg <= SUM_W'(y_reg);
                        np_reg <= 12'd1;
                    end else if (np_reg != TALLY_MAX) begin
                        sx_reg <= sx_reg + SUM_W'(x_reg);
                        sy_reg <= sy_reg + SUM_W'(y_reg);
                        np_reg <= np_reg + 1'b1;
                    end
                end
            end
        end
    end

endmodule

>>> sv/lidar_scan_closest_cluster.sv
// lidar_scan_closest_cluster: segments one lidar scan and reports the
// closest segment mean
// s_ channel: one range sample per beat (s_range_mm, s_no_return,
// s_scan_last), valid/ready handshake
// m_ channel: one result beat per scan, issued after the beat that has
// s_scan_last set; other beats give no result
// cfg channel: register index and data; the user must write only while the block is idle, the block does not enforce it
// per sample: eight trig multiply steps, scale, gap check, break
// decision and update, then idle before the next sample is taken; a
// segment close adds a 30-step restoring divider and a compare
// the result beat follows the last beat of a scan, after up to two
// segment closes on that sample
// one sample is handled at a time; s_ready is low while one is in work
// reset (aresetn low, synchronous) loads register defaults and clears
// all scan state
// a stalled m_ready holds the result beat and blocks new samples until
// it is taken
module lidar_scan_closest_cluster
    import lscc_pkg::*;
#(
    parameter int MAX_POINTS = 2048
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_range_mm,
    input  logic                s_no_return,
    input  logic                s_scan_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [16:0]  m_cluster_x_mm,
    output logic signed [16:0]  m_cluster_y_mm,
    output logic                m_cluster_found,
    output logic [11:0]         m_valid_points,
    output logic [11:0]         m_segment_total,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    lscc_cmd_t  cmd;
    lscc_stat_t stat;

    // registers take writes at any time
    assign cfg_ready = 1'b1;

    lscc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .stat    (stat),
        .cmd     (cmd)
    );

    lscc_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_range_mm      (s_range_mm),
        .s_no_return     (s_no_return),
        .s_scan_last     (s_scan_last),
        .m_cluster_x_mm  (m_cluster_x_mm),
        .m_cluster_y_mm  (m_cluster_y_mm),
        .m_cluster_found (m_cluster_found),
        .m_valid_points  (m_valid_points),
        .m_segment_total (m_segment_total)
    );

endmodule
